>>> sv/fsfl_pkg.sv
// ----------------------------------------------------------------------------
// fsfl_pkg
// Shared types and constants of the fixed-slot free-list allocator.
// ----------------------------------------------------------------------------
package fsfl_pkg;

  // Pool geometry
  localparam int MAX_SLOTS = 256;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);      // slot index width
  localparam int COUNT_W   = $clog2(MAX_SLOTS + 1);  // counts up to MAX_SLOTS

  // Field widths
  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 13;
  localparam int GROW_W    = 9;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  // Width for growth arithmetic, covers both counts and grow_count
  localparam int CALC_W    = (COUNT_W > GROW_W) ? COUNT_W : GROW_W;

  // Divider
  localparam int DIV_STEPS = ADDR_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_FREE     = 2'd1,
    CMD_FREE_ALL = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_OOM          = 2'd1,
    ST_NOT_SLOT     = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOL_BASE  = 2'd0,
    REG_ITEM_SIZE  = 2'd1,
    REG_GROW_COUNT = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GROW,
    S_POP,
    S_POP_DATA,
    S_DIV_START,
    S_DIV_WAIT,
    S_FREE_CHECK,
    S_RESP
  } state_e;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] quotient;
    logic [SIZE_W-1:0] remainder;
  } div_rsp_t;

endpackage

>>> sv/fsfl_ifs.sv
// ----------------------------------------------------------------------------
// fsfl_ifs
// Valid/ready channels of the allocator: command, result and register write.
// ----------------------------------------------------------------------------
interface fsfl_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [fsfl_pkg::CMD_W-1:0]  command;
  logic [fsfl_pkg::ADDR_W-1:0] slot_address;

  modport source (output valid, output command, output slot_address, input ready);
  modport sink   (input valid, input command, input slot_address, output ready);
endinterface

interface fsfl_res_if;
  logic                          valid;
  logic                          ready;
  logic [fsfl_pkg::ADDR_W-1:0]   granted_address;
  logic [fsfl_pkg::STATUS_W-1:0] status;
  logic [fsfl_pkg::COUNT_W-1:0]  live_count;

  modport source (output valid, output granted_address, output status,
                  output live_count, input ready);
  modport sink   (input valid, input granted_address, input status,
                  input live_count, output ready);
endinterface

interface fsfl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fsfl_pkg::CFG_IDX_W-1:0] index;
  logic [fsfl_pkg::ADDR_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/fixed_slot_free_list_allocator.sv
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator
// Fixed-size slot pool with a LIFO free list, double-free bitmap and free-all.
// ----------------------------------------------------------------------------
//  channel  role    payload                                   handshake
//  cmd      sink    command, slot_address                     valid/ready
//  res      source  granted_address, status, live_count       valid/ready
//  cfg      sink    index, data (pool_base/item_size/grow)    valid/ready
//
//  One command at a time; states below lead from accept to the result register.
//  Alloc, non-empty list: S_POP, S_POP_DATA, S_RESP; free-all and others: S_RESP.
//  Alloc that grows the pool: S_GROW first, one link per cycle; at full pool: S_RESP.
//  Free: S_DIV_START, S_DIV_WAIT, S_FREE_CHECK, S_RESP, or S_RESP alone at stride 0.
//  rst is synchronous; the link and free-bit RAMs are not cleared, every entry
//  below enabled_slots is written by a grow before it is read. A result waits
//  in the output register while res stalls; a new command is taken once the
//  previous result is registered.
// ----------------------------------------------------------------------------
module fixed_slot_free_list_allocator (
  input  logic    clk,
  input  logic    rst,
  fsfl_cmd_if.sink   cmd,
  fsfl_res_if.source res,
  fsfl_cfg_if.sink   cfg
);

  localparam int SLOT_W  = fsfl_pkg::SLOT_W;
  localparam int COUNT_W = fsfl_pkg::COUNT_W;
  localparam int CALC_W  = fsfl_pkg::CALC_W;
  localparam int ADDR_W  = fsfl_pkg::ADDR_W;
  localparam int SIZE_W  = fsfl_pkg::SIZE_W;
  localparam int PROD_W  = SLOT_W + SIZE_W;

  fsfl_pkg::state_e state, state_next;

  // Configuration registers
  logic [ADDR_W-1:0]           pool_base;
  logic [SIZE_W-1:0]           item_size;
  logic [fsfl_pkg::GROW_W-1:0] grow_count;

  // Allocator state
  logic [SLOT_W-1:0]    free_head;
  logic [COUNT_W-1:0]   enabled_slots;
  logic [COUNT_W-1:0]   allocated_count;

  // Working registers
  logic [ADDR_W-1:0]    offset;
  logic [COUNT_W-1:0]   grow_ctr;
  logic [COUNT_W-1:0]   grow_end;
  logic [SLOT_W-1:0]    pop_idx;
  logic [PROD_W-1:0]    product;
  logic [ADDR_W-1:0]    rsp_granted;
  fsfl_pkg::status_e    rsp_status;

  // Output register
  logic                 out_valid;
  logic [ADDR_W-1:0]    out_granted;
  fsfl_pkg::status_e    out_status;
  logic [COUNT_W-1:0]   out_count;

  // Link RAM
  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_waddr;
  logic [SLOT_W-1:0]    ram_rdata;

  // Free-bit RAM
  logic                 free_we;
  logic [SLOT_W-1:0]    free_waddr;
  logic                 free_wdata;
  logic                 free_bit;

  // Divider
  fsfl_pkg::div_req_t   div_req;
  fsfl_pkg::div_rsp_t   div_rsp;

  // Growth size: min(max(grow_count,1), room left)
  logic [CALC_W-1:0]    grow_eff;
  logic [CALC_W-1:0]    room;
  logic [CALC_W-1:0]    grow_n;
  logic                 cmd_fire;
  logic                 out_load;
  logic                 last_grow;
  logic [SLOT_W-1:0]    free_idx;
  logic                 free_bad_slot;
  logic                 free_ok;

  assign grow_eff = (grow_count == '0) ? CALC_W'(1) : CALC_W'(grow_count);
  assign room     = CALC_W'(fsfl_pkg::MAX_SLOTS) - CALC_W'(enabled_slots);
  assign grow_n   = (grow_eff < room) ? grow_eff : room;

  assign cmd_fire  = cmd.valid && cmd.ready;
  assign out_load  = (state == fsfl_pkg::S_RESP) && (!out_valid || res.ready);
  assign last_grow = (grow_ctr + 1'b1) == grow_end;

  // Free bit is read as the divider finishes, valid in S_FREE_CHECK
  assign free_idx      = div_rsp.quotient[SLOT_W-1:0];
  assign free_bad_slot = (div_rsp.remainder != '0) ||
                         (div_rsp.quotient >= ADDR_W'(enabled_slots));
  assign free_ok       = !free_bad_slot && !free_bit;

  assign cmd.ready = (state == fsfl_pkg::S_IDLE);
  assign cfg.ready = 1'b1;

  assign res.valid           = out_valid;
  assign res.granted_address = out_granted;
  assign res.status          = out_status;
  assign res.live_count      = out_count;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= '0;
      item_size  <= SIZE_W'(4);
      grow_count <= fsfl_pkg::GROW_W'(16);
    end else if (cfg.valid && cfg.ready) begin
      case (fsfl_pkg::cfg_reg_e'(cfg.index))
        fsfl_pkg::REG_POOL_BASE:  pool_base  <= cfg.data;
        fsfl_pkg::REG_ITEM_SIZE:  item_size  <= cfg.data[SIZE_W-1:0];
        fsfl_pkg::REG_GROW_COUNT: grow_count <= cfg.data[fsfl_pkg::GROW_W-1:0];
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fsfl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and unit controls
  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = offset;
    div_req.divisor  = item_size;
    ram_we           = 1'b0;
    ram_waddr        = grow_ctr[SLOT_W-1:0];
    free_we          = 1'b0;
    free_waddr       = grow_ctr[SLOT_W-1:0];
    free_wdata       = 1'b1;
    case (state)
      fsfl_pkg::S_IDLE: begin
        if (cmd_fire) begin
          case (fsfl_pkg::cmd_e'(cmd.command))
            fsfl_pkg::CMD_ALLOC: begin
              if (allocated_count < enabled_slots) begin
                state_next = fsfl_pkg::S_POP;
              end else if (enabled_slots == COUNT_W'(fsfl_pkg::MAX_SLOTS)) begin
                state_next = fsfl_pkg::S_RESP;
              end else begin
                state_next = fsfl_pkg::S_GROW;
              end
            end
            fsfl_pkg::CMD_FREE: begin
              state_next = (item_size == '0) ? fsfl_pkg::S_RESP
                                             : fsfl_pkg::S_DIV_START;
            end
            default: state_next = fsfl_pkg::S_RESP;
          endcase
        end
      end
      fsfl_pkg::S_GROW: begin
        ram_we  = 1'b1;
        free_we = 1'b1;
        if (last_grow) begin
          state_next = fsfl_pkg::S_POP;
        end
      end
      fsfl_pkg::S_POP:      state_next = fsfl_pkg::S_POP_DATA;
      fsfl_pkg::S_POP_DATA: begin
        free_we    = 1'b1;
        free_waddr = pop_idx;
        free_wdata = 1'b0;
        state_next = fsfl_pkg::S_RESP;
      end
      fsfl_pkg::S_DIV_START: begin
        div_req.start = 1'b1;
        state_next    = fsfl_pkg::S_DIV_WAIT;
      end
      fsfl_pkg::S_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = fsfl_pkg::S_FREE_CHECK;
        end
      end
      fsfl_pkg::S_FREE_CHECK: begin
        ram_waddr  = free_idx;
        ram_we     = free_ok;
        free_waddr = free_idx;
        free_we    = free_ok;
        state_next = fsfl_pkg::S_RESP;
      end
      fsfl_pkg::S_RESP: begin
        if (out_load) begin
          state_next = fsfl_pkg::S_IDLE;
        end
      end
      default: state_next = fsfl_pkg::S_IDLE;
    endcase
  end

  // Allocator state
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head       <= '0;
      enabled_slots   <= '0;
      allocated_count <= '0;
    end else begin
      case (state)
        fsfl_pkg::S_IDLE: begin
          if (cmd_fire && (fsfl_pkg::cmd_e'(cmd.command) == fsfl_pkg::CMD_FREE_ALL)) begin
            free_head       <= '0;
            enabled_slots   <= '0;
            allocated_count <= '0;
          end
        end
        fsfl_pkg::S_GROW: begin
          // push slots in ascending order
          free_head <= grow_ctr[SLOT_W-1:0];
          if (last_grow) begin
            enabled_slots <= grow_end;
          end
        end
        fsfl_pkg::S_POP_DATA: begin
          free_head       <= ram_rdata;
          allocated_count <= allocated_count + 1'b1;
        end
        fsfl_pkg::S_FREE_CHECK: begin
          if (free_ok) begin
            free_head <= free_idx;
            if (allocated_count != '0) begin
              allocated_count <= allocated_count - 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers and staged result
  always_ff @(posedge clk) begin
    case (state)
      fsfl_pkg::S_IDLE: begin
        rsp_granted <= '0;
        grow_ctr    <= enabled_slots;
        grow_end    <= enabled_slots + COUNT_W'(grow_n);
        offset      <= cmd.slot_address - pool_base;
        if ((fsfl_pkg::cmd_e'(cmd.command) == fsfl_pkg::CMD_ALLOC) &&
            (allocated_count >= enabled_slots) &&
            (enabled_slots == COUNT_W'(fsfl_pkg::MAX_SLOTS))) begin
          rsp_status <= fsfl_pkg::ST_OOM;
        end else if (fsfl_pkg::cmd_e'(cmd.command) == fsfl_pkg::CMD_FREE) begin
          rsp_status <= fsfl_pkg::ST_NOT_SLOT;
        end else begin
          rsp_status <= fsfl_pkg::ST_OK;
        end
      end
      fsfl_pkg::S_GROW: begin
        grow_ctr <= grow_ctr + 1'b1;
      end
      fsfl_pkg::S_POP: begin
        pop_idx <= free_head;
        product <= PROD_W'(free_head) * PROD_W'(item_size);
      end
      fsfl_pkg::S_POP_DATA: begin
        rsp_granted <= pool_base + ADDR_W'(product);
        rsp_status  <= fsfl_pkg::ST_OK;
      end
      fsfl_pkg::S_FREE_CHECK: begin
        if (free_bad_slot) begin
          rsp_status <= fsfl_pkg::ST_NOT_SLOT;
        end else if (free_bit) begin
          rsp_status <= fsfl_pkg::ST_ALREADY_FREE;
        end else begin
          rsp_status <= fsfl_pkg::ST_OK;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_granted <= rsp_granted;
      out_status  <= rsp_status;
      out_count   <= allocated_count;
    end
  end

  // Link RAM, one link per slot
  fsfl_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (fsfl_pkg::MAX_SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (free_head),
    .raddr (free_head),
    .rdata (ram_rdata)
  );

  // Free-bit RAM, double-free bitmap
  fsfl_ram #(
    .WIDTH (1),
    .DEPTH (fsfl_pkg::MAX_SLOTS)
  ) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (free_wdata),
    .raddr (free_idx),
    .rdata (free_bit)
  );

  // 32-step divider for the slot boundary check
  fsfl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Checks
  a_count_in_pool: assert property (@(posedge clk) disable iff (rst)
    allocated_count <= enabled_slots)
    else $error("allocated count exceeds enabled slots");

  a_enabled_bound: assert property (@(posedge clk) disable iff (rst)
    enabled_slots <= COUNT_W'(fsfl_pkg::MAX_SLOTS))
    else $error("enabled slots beyond pool size");

  a_grow_range: assert property (@(posedge clk) disable iff (rst)
    (state == fsfl_pkg::S_GROW) |-> (grow_ctr < grow_end))
    else $error("growth counter ran past its end");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == fsfl_pkg::S_DIV_WAIT))
    else $error("divider finished outside of a free");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == fsfl_pkg::S_POP) |-> (allocated_count < enabled_slots))
    else $error("pop from an empty free list");

endmodule

>>> sv/fsfl_ram.sv
// ----------------------------------------------------------------------------
// fsfl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fsfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/fsfl_div.sv
// ----------------------------------------------------------------------------
// fsfl_div
// Restoring divider, one quotient bit per cycle, for the free address check.
// ----------------------------------------------------------------------------
module fsfl_div (
  input  logic               clk,
  input  logic               rst,
  input  fsfl_pkg::div_req_t req,
  output fsfl_pkg::div_rsp_t rsp
);

  logic                            busy;
  logic                            done;
  logic [fsfl_pkg::DIV_CNT_W-1:0]  cnt;
  logic [fsfl_pkg::ADDR_W-1:0]     quo;
  logic [fsfl_pkg::SIZE_W-1:0]     rem;
  logic [fsfl_pkg::SIZE_W-1:0]     divisor;
  logic [fsfl_pkg::SIZE_W:0]       shifted;
  logic                            fits;

  // One trial subtract per cycle
  assign shifted = {rem, quo[fsfl_pkg::ADDR_W-1]};
  assign fits    = shifted >= {1'b0, divisor};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == fsfl_pkg::DIV_CNT_W'(fsfl_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      quo <= {quo[fsfl_pkg::ADDR_W-2:0], fits};
      rem <= fits ? fsfl_pkg::SIZE_W'(shifted - {1'b0, divisor})
                  : shifted[fsfl_pkg::SIZE_W-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

>>> test/fixed_slot_free_list_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator_tb
// Self-checking bench for the slot pool allocator. A clocked driver feeds
// alloc / free / free-all transactions from a queue, a clocked monitor
// predicts each result and compares granted_address, status and live_count.
// Directed items cover wraparound, zero stride and grow sizes, misaligned and
// out-of-range frees and double frees. Random phases add sender and receiver
// idling, and a fill run drives the pool to full while the receiver holds off.
// ----------------------------------------------------------------------------
module fixed_slot_free_list_allocator_tb;

  localparam int MAX_SLOTS = fsfl_pkg::MAX_SLOTS;
  localparam int SLOT_W    = fsfl_pkg::SLOT_W;
  localparam int COUNT_W   = fsfl_pkg::COUNT_W;
  localparam int ADDR_W    = fsfl_pkg::ADDR_W;
  localparam int SIZE_W    = fsfl_pkg::SIZE_W;
  localparam int GROW_W    = fsfl_pkg::GROW_W;
  localparam int CMD_W     = fsfl_pkg::CMD_W;

  localparam int QUIET_LIMIT = 3000;   // cycles with no transaction at all
  localparam int HOLD_CYCLES = 400;    // long receiver hold-off
  localparam int PRINT_LIMIT = 100;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  typedef struct {
    logic [CMD_W-1:0]  op;
    logic [ADDR_W-1:0] addr;
  } pool_cmd_t;

  typedef struct {
    logic [ADDR_W-1:0]  granted;
    fsfl_pkg::status_e  status;
    logic [COUNT_W-1:0] live;
  } pool_result_t;

  logic clk = 1'b0;
  logic rst;

  fsfl_cmd_if cmd_ch();
  fsfl_res_if res_ch();
  fsfl_cfg_if cfg_ch();

  fixed_slot_free_list_allocator uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  // Clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the pool: register copies and free-list state
  logic [ADDR_W-1:0]  cfg_pool_base;
  logic [SIZE_W-1:0]  cfg_item_size;
  logic [GROW_W-1:0]  cfg_grow_count;
  logic [SLOT_W-1:0]  link_mem [MAX_SLOTS];
  logic [SLOT_W-1:0]  list_head;
  logic [COUNT_W-1:0] slots_enabled;
  logic [COUNT_W-1:0] slots_live;
  logic [MAX_SLOTS-1:0] slot_free;

  // Stimulus and scoreboard
  pool_cmd_t    pending_commands[$];
  pool_result_t expected_results[$];
  pool_cmd_t    next_item;
  pool_result_t predicted;
  pool_result_t oldest;
  int  cmds_queued = 0;
  int  cmds_accepted = 0;
  int  results_seen = 0;
  int  mismatch_count = 0;
  int  status_seen [4] = '{0, 0, 0, 0};
  int  peak_live = 0;
  int  phases_run = 0;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  fill_pressure;
  bit  cmd_taken = 1'b0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  quiet_cycles = 0;

  function automatic logic [ADDR_W-1:0] slot_address_of(int unsigned idx);
    logic [ADDR_W-1:0] stride;
    stride = ADDR_W'(cfg_item_size);
    return cfg_pool_base + idx * stride;
  endfunction

  function automatic void push_free_slot(logic [SLOT_W-1:0] slot);
    link_mem[slot] = list_head;
    list_head      = slot;
    slot_free[slot] = 1'b1;
  endfunction

  function automatic void empty_pool();
    slot_free     = '0;
    list_head     = '0;
    slots_enabled = '0;
    slots_live    = '0;
  endfunction

  // Expected outcome of one command; updates the shadow state
  task automatic predict_command(input logic [CMD_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                 output pool_result_t outcome);
    int unsigned add;
    int unsigned room;
    int unsigned i;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] stride;
    logic [SLOT_W-1:0] slot;
    outcome.granted = '0;
    outcome.status  = fsfl_pkg::ST_OK;
    case (op)
      fsfl_pkg::CMD_ALLOC: begin
        // empty list: enable the next block, pushed ascending so the top comes out first
        if (slots_live >= slots_enabled) begin
          add  = (cfg_grow_count == '0) ? 1 : cfg_grow_count;
          room = MAX_SLOTS - slots_enabled;
          if (add > room) add = room;
          for (i = 0; i < add; i++) begin
            slot = SLOT_W'(slots_enabled + i);
            push_free_slot(slot);
          end
          slots_enabled = COUNT_W'(slots_enabled + add);
        end
        if (slots_live >= slots_enabled) begin
          outcome.status = fsfl_pkg::ST_OOM;
        end else begin
          slot            = list_head;
          list_head       = link_mem[slot];
          slot_free[slot] = 1'b0;
          slots_live      = slots_live + 1'b1;
          outcome.granted = slot_address_of(slot);
        end
      end
      fsfl_pkg::CMD_FREE: begin
        // offset wraps below base, so those land far outside the pool
        offset = addr - cfg_pool_base;
        stride = ADDR_W'(cfg_item_size);
        if (stride == '0 || offset % stride != '0 || offset / stride >= slots_enabled) begin
          outcome.status = fsfl_pkg::ST_NOT_SLOT;
        end else begin
          slot = SLOT_W'(offset / stride);
          if (slot_free[slot]) begin
            outcome.status = fsfl_pkg::ST_ALREADY_FREE;
          end else begin
            push_free_slot(slot);
            if (slots_live != '0) slots_live = slots_live - 1'b1;
          end
        end
      end
      fsfl_pkg::CMD_FREE_ALL: begin
        empty_pool();
      end
      default: ;  // unknown command leaves everything alone
    endcase
    outcome.live = slots_live;
  endtask

  task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                 input logic [ADDR_W-1:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
               $time, results_seen, what, got, want);
    mismatch_count++;
  endtask

  // Command driver: change on falling edge, one item per accepted transaction
  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_taken) begin
      if (pending_commands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = pending_commands.pop_front();
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= next_item.op;
        cmd_ch.slot_address <= next_item.addr;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off during the fill run
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (fill_pressure && !hold_done) begin
      res_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on accepted commands, check accepted results in order
  always @(posedge clk) begin
    if (rst) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= cmd_ch.valid && cmd_ch.ready;
      if (cmd_ch.valid && cmd_ch.ready) begin
        predict_command(cmd_ch.command, cmd_ch.slot_address, predicted);
        expected_results.push_back(predicted);
        cmds_accepted++;
      end
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, granted_address", res_ch.granted_address, '0);
        end else begin
          oldest = expected_results.pop_front();
          if (res_ch.granted_address !== oldest.granted)
            report_mismatch("granted_address", res_ch.granted_address, oldest.granted);
          if (res_ch.status !== oldest.status)
            report_mismatch("status", ADDR_W'(res_ch.status), ADDR_W'(oldest.status));
          if (res_ch.live_count !== oldest.live)
            report_mismatch("live_count", ADDR_W'(res_ch.live_count), ADDR_W'(oldest.live));
          status_seen[oldest.status]++;
          if (int'(oldest.live) > peak_live) peak_live = int'(oldest.live);
        end
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no transaction
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_register(input fsfl_pkg::cfg_reg_e idx, input logic [ADDR_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    case (idx)
      fsfl_pkg::REG_POOL_BASE:  cfg_pool_base  = value;
      fsfl_pkg::REG_ITEM_SIZE:  cfg_item_size  = value[SIZE_W-1:0];
      fsfl_pkg::REG_GROW_COUNT: cfg_grow_count = value[GROW_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_settings(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
                                input logic [GROW_W-1:0] grow);
    write_register(fsfl_pkg::REG_POOL_BASE, base);
    write_register(fsfl_pkg::REG_ITEM_SIZE, {{(ADDR_W-SIZE_W){1'b0}}, size});
    write_register(fsfl_pkg::REG_GROW_COUNT, {{(ADDR_W-GROW_W){1'b0}}, grow});
  endtask

  // Block goes idle: every queued command taken and every result back
  task automatic wait_for_drain();
    do @(negedge clk);
    while (cmds_accepted != cmds_queued || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic start_phase(input int send_pct, input int stall_pct);
    @(posedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    phases_run++;
  endtask

  function automatic void queue_command(logic [CMD_W-1:0] op, logic [ADDR_W-1:0] addr);
    pending_commands.push_back('{op, addr});
    cmds_queued++;
  endfunction

  // Mostly slot-aligned frees, some misaligned, below base or anywhere
  function automatic logic [ADDR_W-1:0] pick_free_address(int unsigned span);
    logic [ADDR_W-1:0] aligned;
    aligned = slot_address_of($urandom_range(span, 0));
    case ($urandom_range(9))
      0: return $urandom();
      1: return aligned + $urandom_range(8191, 1);
      2: return cfg_pool_base - $urandom_range(4096, 1);
      default: return aligned;
    endcase
  endfunction

  task automatic queue_random_mix(input int count, input int unsigned span);
    int roll;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 48)
        queue_command(fsfl_pkg::CMD_ALLOC, $urandom());
      else if (roll < 92)
        queue_command(fsfl_pkg::CMD_FREE, pick_free_address(span));
      else if (roll < 96)
        queue_command(fsfl_pkg::CMD_FREE_ALL, $urandom());
      else
        queue_command(CMD_UNKNOWN, $urandom());
    end
  endtask

  // Main sequence
  initial begin
    int p;
    rst                 = 1'b1;
    cmd_ch.valid        = 1'b0;
    cmd_ch.command      = '0;
    cmd_ch.slot_address = '0;
    res_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    fill_pressure       = 1'b0;
    cfg_pool_base       = '0;
    cfg_item_size       = 13'd4;
    cfg_grow_count      = 9'd16;
    foreach (link_mem[k]) link_mem[k] = '0;
    empty_pool();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: base 0, stride 4, grow 16
    start_phase(0, 0);
    queue_command(fsfl_pkg::CMD_FREE, 32'h0000_0000);      // nothing enabled yet
    queue_command(fsfl_pkg::CMD_ALLOC, 32'hFFFF_FFFF);     // grows, top slot first
    queue_command(fsfl_pkg::CMD_ALLOC, 32'h0000_0000);
    queue_command(fsfl_pkg::CMD_FREE, 32'd60);
    queue_command(fsfl_pkg::CMD_FREE, 32'd60);             // double free
    queue_command(fsfl_pkg::CMD_FREE, 32'd61);             // misaligned
    queue_command(fsfl_pkg::CMD_FREE, 32'd64);             // past the enabled range
    queue_command(fsfl_pkg::CMD_FREE, 32'd0);              // enabled but never handed out
    queue_command(CMD_UNKNOWN, 32'hFFFF_FFFF);
    queue_command(fsfl_pkg::CMD_FREE_ALL, 32'h0000_0000);
    queue_command(fsfl_pkg::CMD_ALLOC, 32'h0000_0000);

    // Base near the top so slot addresses wrap; grow of zero acts as one
    wait_for_drain();
    apply_settings(32'hFFFF_FFF0, 13'd4096, 9'd0);
    start_phase(0, 0);
    queue_command(fsfl_pkg::CMD_ALLOC, 32'h0);
    queue_command(fsfl_pkg::CMD_ALLOC, 32'h0);
    queue_command(fsfl_pkg::CMD_FREE, 32'h0000_0FF0);      // wrapped slot 1
    queue_command(fsfl_pkg::CMD_FREE, 32'h0000_0000);
    queue_command(fsfl_pkg::CMD_FREE, 32'hFFFF_EFF0);      // below base, aligned offset
    queue_command(fsfl_pkg::CMD_ALLOC, 32'h0);

    // Zero stride, grow larger than the pool
    wait_for_drain();
    apply_settings(32'hA5A5_A5A5, 13'd0, 9'h1FF);
    start_phase(0, 0);
    queue_command(fsfl_pkg::CMD_FREE_ALL, 32'h0);
    queue_command(fsfl_pkg::CMD_ALLOC, 32'h0);
    queue_command(fsfl_pkg::CMD_FREE, 32'hA5A5_A5A5);
    queue_command(fsfl_pkg::CMD_FREE_ALL, 32'hFFFF_FFFF);

    // Widest stride
    wait_for_drain();
    apply_settings(32'h5A5A_5A5A, 13'h1FFF, 9'd2);
    start_phase(0, 0);
    queue_command(fsfl_pkg::CMD_ALLOC, 32'h0);
    queue_command(fsfl_pkg::CMD_FREE, 32'h5A5A_5A5A + 32'h1FFF);
    queue_command(fsfl_pkg::CMD_FREE, 32'h5A5A_5A5A + 32'h1FFE);
    queue_command(fsfl_pkg::CMD_ALLOC, 32'h0);

    // Random phases, pool state carried across register changes
    for (p = 0; p < 4; p++) begin
      wait_for_drain();
      case (p)
        0: begin
          apply_settings(32'h0, 13'd4, 9'd16);
          start_phase(0, 0);
        end
        1: begin
          apply_settings($urandom(), SIZE_W'($urandom_range(8191, 1)),
                         GROW_W'($urandom_range(8, 0)));
          start_phase(70, 0);
        end
        2: begin
          apply_settings($urandom(), 13'd4096, 9'd256);
          start_phase(0, 70);
        end
        default: begin
          apply_settings($urandom(), SIZE_W'($urandom_range(64, 4)), 9'd1);
          start_phase(12, 12);
        end
      endcase
      queue_random_mix(35, 40);
    end

    // Fill to full: grows of 100 end in a partial one, then out of memory.
    // The receiver holds off at the start so the block backs up.
    wait_for_drain();
    apply_settings($urandom(), SIZE_W'($urandom_range(4096, 4)), 9'd100);
    start_phase(12, 12);
    fill_pressure = 1'b1;
    queue_command(fsfl_pkg::CMD_FREE_ALL, $urandom());
    repeat (300) begin
      if ($urandom_range(99) < 95)
        queue_command(fsfl_pkg::CMD_ALLOC, $urandom());
      else
        queue_command(fsfl_pkg::CMD_FREE, pick_free_address(255));
    end
    repeat (4) queue_command(fsfl_pkg::CMD_ALLOC, $urandom());

    wait_for_drain();
    repeat (40) @(negedge clk);

    $display("Covered %0d commands over %0d phases, peak live count %0d.",
             cmds_accepted, phases_run, peak_live);
    $display("Statuses: ok %0d, out of memory %0d, not a slot %0d, already free %0d;",
             status_seen[fsfl_pkg::ST_OK], status_seen[fsfl_pkg::ST_OOM],
             status_seen[fsfl_pkg::ST_NOT_SLOT], status_seen[fsfl_pkg::ST_ALREADY_FREE]);
    $display("%0d mismatches.", mismatch_count);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> fixed_slot_free_list_allocator.f
sv/fsfl_pkg.sv
sv/fsfl_ifs.sv
sv/fsfl_ram.sv
sv/fsfl_div.sv
sv/fixed_slot_free_list_allocator.sv
test/fixed_slot_free_list_allocator_tb.sv
